@@ hdl/sbfc_pkg.sv @@
// Constants and status codes for the servo bus frame checker.
// Has no dependencies. It is imported by servo_bus_frame_checker.
`timescale 1ns / 1ps

package sbfc_pkg;

  localparam logic [7:0] HDR_BYTE     = 8'h55;
  localparam logic [7:0] BROADCAST_ID = 8'hFE;
  localparam logic [8:0] MIN_FRAME    = 9'd6;
  localparam logic [7:0] LEN_OVERHEAD = 8'd3;
  localparam logic [7:0] MAX_LENGTH   = 8'd252;
  localparam logic [8:0] POS_MAX      = 9'd511;

  // Parameter bytes kept for the result; the result word holds four at most.
  localparam int KEPT_PARAM_BYTES = 4;
  localparam int KEPT_BYTES = (KEPT_PARAM_BYTES < 4) ? KEPT_PARAM_BYTES : 4;
  // Position of the first parameter byte in the buffer.
  localparam logic [8:0] FIRST_PARAM_POS = 9'd5;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_OWN_ID = 3'd0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_OTHER_ID  = 3'd5,
    ST_BAD_SUM   = 3'd6
  } status_t;

endpackage

@@ hdl/servo_bus_frame_checker.sv @@
// Servo bus frame checker: checks one frame per receive buffer and reports it.
// Depends on sbfc_pkg for constants and status codes.
// A flagged byte in the input register has its result loaded into the output register
// once that register is free.
// Throughput: one byte per cycle, set by the single per-byte update of the frame state;
// the input stalls only while a finished result waits on a stalled output.
// Reset (rst, synchronous, active high) empties both stages, clears the frame
// state and sets own_id to the broadcast id 0xFE.
`timescale 1ns / 1ps

module servo_bus_frame_checker
  import sbfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_buffer,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  frame_status,
  output logic [7:0]  sender_id,
  output logic [7:0]  command_code,
  output logic [7:0]  param_len,
  output logic [31:0] param_word
);

  // Configuration register.
  logic [7:0] own_id;

  // Input register stage.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Frame state, cleared after each buffer.
  logic [8:0]  byte_position;
  logic        header_good;
  logic [7:0]  frame_id;
  logic [7:0]  frame_length;
  logic [7:0]  frame_command;
  logic [7:0]  running_sum;
  logic [31:0] kept_params;
  logic [7:0]  received_check;
  logic        frame_complete;

  // Next values of the frame state as the byte in the input stage leaves them.
  logic [8:0]  byte_position_next;
  logic        header_good_next;
  logic [7:0]  frame_id_next;
  logic [7:0]  frame_length_next;
  logic [7:0]  frame_command_next;
  logic [7:0]  running_sum_next;
  logic [31:0] kept_params_next;
  logic [7:0]  received_check_next;
  logic        frame_complete_next;

  logic        out_free;
  logic        s1_go;
  logic        cfg_write;
  logic [8:0]  check_pos;
  status_t     status;
  logic        keep_fields;
  logic        keep_params;

  // The output register can take a new result when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;
  // A byte that closes a buffer needs room in the output register; others never wait.
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_go;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr == ADDR_OWN_ID) ? {24'd0, own_id} : 32'd0;

  // The checksum byte sits at position length + 2.
  assign check_pos = {1'b0, frame_length} + 9'd2;

  always_comb begin
    byte_position_next  = byte_position;
    header_good_next    = header_good;
    frame_id_next       = frame_id;
    frame_length_next   = frame_length;
    frame_command_next  = frame_command;
    running_sum_next    = running_sum;
    kept_params_next    = kept_params;
    received_check_next = received_check;
    frame_complete_next = frame_complete;

    if (byte_position <= 9'd1) begin
      if (s1_byte != HDR_BYTE) begin
        header_good_next = 1'b0;
      end
    end else if (byte_position == 9'd2) begin
      frame_id_next    = s1_byte;
      running_sum_next = running_sum + s1_byte;
    end else if (byte_position == 9'd3) begin
      frame_length_next = s1_byte;
      running_sum_next  = running_sum + s1_byte;
    end else if (byte_position == 9'd4) begin
      frame_command_next = s1_byte;
      running_sum_next   = running_sum + s1_byte;
    end else if (!frame_complete && frame_length >= LEN_OVERHEAD) begin
      if (byte_position < check_pos) begin
        running_sum_next = running_sum + s1_byte;
        for (int i = 0; i < KEPT_BYTES; i++) begin
          if (byte_position == FIRST_PARAM_POS + 9'(i)) begin
            kept_params_next[8*i +: 8] = s1_byte;
          end
        end
      end else if (byte_position == check_pos) begin
        received_check_next = s1_byte;
        frame_complete_next = 1'b1;
      end
    end

    byte_position_next = (byte_position < POS_MAX) ? byte_position + 9'd1 : POS_MAX;
  end

  // Checks in order of priority; the first failure decides the status.
  always_comb begin
    if (byte_position_next < MIN_FRAME) begin
      status = ST_SHORT;
    end else if (!header_good_next) begin
      status = ST_BAD_HDR;
    end else if (frame_length_next < LEN_OVERHEAD || frame_length_next > MAX_LENGTH) begin
      status = ST_BAD_LEN;
    end else if (!frame_complete_next) begin
      status = ST_TRUNCATED;
    end else if (frame_id_next != own_id && own_id != BROADCAST_ID) begin
      status = ST_OTHER_ID;
    end else if (received_check_next != ~running_sum_next) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
  end

  // Id and command are reported unless the buffer was too short or the header bad;
  // parameters only when the length byte was valid.
  assign keep_fields = !(status == ST_SHORT || status == ST_BAD_HDR);
  assign keep_params = keep_fields && (status != ST_BAD_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id         <= BROADCAST_ID;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      byte_position  <= 9'd0;
      header_good    <= 1'b1;
      frame_id       <= 8'd0;
      frame_length   <= 8'd0;
      frame_command  <= 8'd0;
      running_sum    <= 8'd0;
      kept_params    <= 32'd0;
      received_check <= 8'd0;
      frame_complete <= 1'b0;
    end else begin
      if (cfg_write && paddr == ADDR_OWN_ID) begin
        own_id <= pwdata[7:0];
      end

      // Input register: refill whenever the held byte moves on or the stage is empty.
      if (!s1_valid || s1_go) begin
        s1_valid <= in_valid;
        if (in_valid) begin
          s1_byte <= rx_byte;
          s1_last <= end_of_buffer;
        end
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (s1_go) begin
        if (s1_last) begin
          out_valid    <= 1'b1;
          frame_status <= status;
          sender_id    <= keep_fields ? frame_id_next : 8'd0;
          command_code <= keep_fields ? frame_command_next : 8'd0;
          param_len    <= keep_params ? frame_length_next - LEN_OVERHEAD : 8'd0;
          param_word   <= keep_params ? kept_params_next : 32'd0;

          // The buffer is done: start afresh for the next one.
          byte_position  <= 9'd0;
          header_good    <= 1'b1;
          frame_id       <= 8'd0;
          frame_length   <= 8'd0;
          frame_command  <= 8'd0;
          running_sum    <= 8'd0;
          kept_params    <= 32'd0;
          received_check <= 8'd0;
          frame_complete <= 1'b0;
        end else begin
          byte_position  <= byte_position_next;
          header_good    <= header_good_next;
          frame_id       <= frame_id_next;
          frame_length   <= frame_length_next;
          frame_command  <= frame_command_next;
          running_sum    <= running_sum_next;
          kept_params    <= kept_params_next;
          received_check <= received_check_next;
          frame_complete <= frame_complete_next;
        end
      end
    end
  end

endmodule
